// ===== hw/rtl/assert_macros.svh =====
// shared assertion macros for the page buffer directory
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PBD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define PBD_ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/pbd_pkg.sv =====
package pbd_pkg;

    // fixed field widths
    localparam int SLOT_OUT_W = 4;
    localparam int FILE_W     = 4;
    localparam int PAGE_W     = 24;

    // victim generator
    localparam int          LFSR_W    = 16;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef enum logic [1:0] {
        OP_FETCH       = 2'd0,
        OP_FETCH_DIRTY = 2'd1,
        OP_CREATE      = 2'd2,
        OP_CLOSE       = 2'd3
    } pbd_op_t;

    typedef enum logic [1:0] {
        SLOT_NEVER = 2'd0,
        SLOT_USED  = 2'd1,
        SLOT_FREED = 2'd2
    } slot_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_VICTIM,
        ST_COMMIT,
        ST_SCAN,
        ST_CLOSE_END
    } pbd_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic capture;
        logic pick;
        logic victim_start;
        logic pick_victim;
        logic commit;
        logic scan_step;
        logic scan_emit;
        logic close_last;
    } pbd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic need_victim;
        logic victim_done;
        logic scan_match;
        logic scan_dirty;
        logic scan_last;
    } pbd_stat_t;

endpackage

// ===== hw/rtl/pbd_victim.sv =====
`include "assert_macros.svh"

module pbd_victim import pbd_pkg::*; #(
    parameter int  SLOTS  = 16,
    localparam int SLOT_W = $clog2(SLOTS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    output logic              done,
    output logic [SLOT_W-1:0] victim_slot
);

    // scaled reciprocal of SLOTS; the quotient estimate is low by at most one
    localparam int                 RECIP_K = LFSR_W + SLOT_W;
    localparam logic [RECIP_K-1:0] RECIP_M = RECIP_K'((1 << RECIP_K) / SLOTS);
    localparam logic [LFSR_W-1:0]  DIVISOR = LFSR_W'(SLOTS);

    // step counter values
    localparam logic [1:0] STEP_QUOT = 2'd2;
    localparam logic [1:0] STEP_REM  = 2'd1;

    logic [LFSR_W-1:0]         lfsr_reg, lfsr_next;
    logic [LFSR_W-1:0]         value_reg;
    logic [LFSR_W+RECIP_K-1:0] product;
    logic [LFSR_W-1:0]         quot_reg;
    logic [LFSR_W-1:0]         rem_wide;
    logic [SLOT_W-1:0]         rem_reg;
    logic [1:0]                cnt_reg;
    logic                      busy_reg;

    // one galois step
    always_comb begin
        lfsr_next = lfsr_reg >> 1;
        if (lfsr_reg[0]) begin
            lfsr_next = lfsr_next ^ LFSR_TAPS;
        end
    end

    // quotient estimate by reciprocal multiplication
    assign product = {{RECIP_K{1'b0}}, value_reg} * {{LFSR_W{1'b0}}, RECIP_M};

    // remainder with one correction step
    always_comb begin
        rem_wide = value_reg - quot_reg * DIVISOR;
        if (rem_wide >= DIVISOR) begin
            rem_wide = rem_wide - DIVISOR;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg <= LFSR_SEED;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            lfsr_reg <= lfsr_next;
            busy_reg <= 1'b1;
            cnt_reg  <= STEP_QUOT;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // remainder datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            value_reg <= lfsr_next;
        end
        if (busy_reg && cnt_reg == STEP_QUOT) begin
            quot_reg <= product[LFSR_W+RECIP_K-1:RECIP_K];
        end
        if (busy_reg && cnt_reg == STEP_REM) begin
            rem_reg <= rem_wide[SLOT_W-1:0];
        end
    end

    assign done        = busy_reg && (cnt_reg == '0);
    assign victim_slot = rem_reg;

    `PBD_ASSERT(a_no_restart, aclk, aresetn, start |-> !busy_reg, "victim restarted while busy")

endmodule

// ===== hw/rtl/pbd_ctrl.sv =====
`include "assert_macros.svh"

module pbd_ctrl import pbd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  pbd_stat_t  stat,
    output pbd_cmd_t   cmd
);

    pbd_state_t state_reg, state_next;
    logic       scan_wb;
    logic       scan_go;

    // close walk: a dirty slot of the file needs the output register
    assign scan_wb = stat.scan_match && stat.scan_dirty;
    assign scan_go = !scan_wb || stat.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (pbd_op_t'(s_operation) == OP_CLOSE) ? ST_SCAN : ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_DECIDE;
            ST_DECIDE: state_next = stat.need_victim ? ST_VICTIM : ST_COMMIT;
            ST_VICTIM: begin
                if (stat.victim_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_go && stat.scan_last) begin
                    state_next = ST_CLOSE_END;
                end
            end
            ST_CLOSE_END: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            ST_LOOKUP: cmd.capture = 1'b1;
            ST_DECIDE: begin
                cmd.victim_start = stat.need_victim;
                cmd.pick         = !stat.need_victim;
            end
            ST_VICTIM: cmd.pick_victim = stat.victim_done;
            ST_COMMIT: cmd.commit = stat.out_free;
            ST_SCAN: begin
                cmd.scan_step = scan_go;
                cmd.scan_emit = scan_wb && stat.out_free;
            end
            ST_CLOSE_END: cmd.close_last = stat.out_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

    `PBD_ASSERT(a_emit_free, aclk, aresetn, (cmd.commit || cmd.scan_emit || cmd.close_last) |-> stat.out_free, "result written into occupied output register")

endmodule

// ===== hw/rtl/pbd_datapath.sv =====
`include "assert_macros.svh"

module pbd_datapath import pbd_pkg::*; #(
    parameter int  SLOTS  = 16,
    localparam int SLOT_W = $clog2(SLOTS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pbd_cmd_t              cmd,
    output pbd_stat_t             stat,
    input  logic [1:0]            s_operation,
    input  logic [FILE_W-1:0]     s_file_id,
    input  logic [PAGE_W-1:0]     s_page_number,
    input  logic                  victim_done,
    input  logic [SLOT_W-1:0]     victim_slot,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SLOT_OUT_W-1:0] m_slot,
    output logic                  m_hit,
    output logic                  m_fill_needed,
    output logic                  m_writeback_needed,
    output logic [FILE_W-1:0]     m_writeback_file,
    output logic [PAGE_W-1:0]     m_writeback_page,
    output logic                  m_last
);

    // slot directory
    slot_state_t       slot_status_reg [SLOTS];
    logic [FILE_W-1:0] slot_file_reg   [SLOTS];
    logic [PAGE_W-1:0] slot_page_reg   [SLOTS];
    logic              slot_dirty_reg  [SLOTS];

    // request being served
    pbd_op_t           req_op_reg;
    logic [FILE_W-1:0] req_file_reg;
    logic [PAGE_W-1:0] req_page_reg;

    logic [SLOTS-1:0] match_vec, never_vec, freed_vec;
    logic [SLOTS-1:0] match_vec_reg, never_vec_reg, freed_vec_reg;
    logic [SLOT_W-1:0] match_idx, never_idx, freed_idx, sel_idx;
    logic              any_match, any_never, any_freed;

    logic [SLOT_W-1:0] target_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] scan_idx_reg;

    logic              target_used;
    logic              old_wb;
    logic              scan_match;
    logic [SLOT_W+SLOT_OUT_W-1:0] target_ext, scan_ext;

    // output register
    logic                  m_valid_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic                  out_hit_reg, out_fill_reg, out_wb_reg, out_last_reg;
    logic [FILE_W-1:0]     out_wb_file_reg;
    logic [PAGE_W-1:0]     out_wb_page_reg;

    // tag compare and slot state vectors, one bit per slot
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match_vec[i] = (slot_status_reg[i] == SLOT_USED) &&
                           (slot_file_reg[i] == req_file_reg) &&
                           (slot_page_reg[i] == req_page_reg);
            never_vec[i] = (slot_status_reg[i] == SLOT_NEVER);
            freed_vec[i] = (slot_status_reg[i] == SLOT_FREED);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_vec_reg <= '0;
            never_vec_reg <= '0;
            freed_vec_reg <= '0;
        end else if (cmd.capture) begin
            match_vec_reg <= match_vec;
            never_vec_reg <= never_vec;
            freed_vec_reg <= freed_vec;
        end
    end

    // lowest match, lowest never used, highest released
    always_comb begin
        match_idx = '0;
        never_idx = '0;
        freed_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (match_vec_reg[i]) begin
                match_idx = SLOT_W'(i);
            end
            if (never_vec_reg[i]) begin
                never_idx = SLOT_W'(i);
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (freed_vec_reg[i]) begin
                freed_idx = SLOT_W'(i);
            end
        end
    end

    assign any_match = |match_vec_reg;
    assign any_never = |never_vec_reg;
    assign any_freed = |freed_vec_reg;
    assign sel_idx   = any_match ? match_idx : (any_never ? never_idx : freed_idx);

    // request capture and slot choice
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_op_reg   <= pbd_op_t'(s_operation);
            req_file_reg <= s_file_id;
            req_page_reg <= s_page_number;
        end
        if (cmd.pick) begin
            target_reg <= sel_idx;
            hit_reg    <= any_match;
        end else if (cmd.pick_victim) begin
            target_reg <= victim_slot;
            hit_reg    <= 1'b0;
        end
    end

    // close walk index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
        end else if (cmd.load_req) begin
            scan_idx_reg <= '0;
        end else if (cmd.scan_step) begin
            scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
        end
    end

    assign scan_match = (slot_status_reg[scan_idx_reg] == SLOT_USED) &&
                        (slot_file_reg[scan_idx_reg] == req_file_reg);

    // slot state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_status_reg[i] <= SLOT_NEVER;
            end
        end else begin
            if (cmd.commit && !hit_reg) begin
                slot_status_reg[target_reg] <= SLOT_USED;
            end
            if (cmd.scan_step && scan_match) begin
                slot_status_reg[scan_idx_reg] <= SLOT_FREED;
            end
        end
    end

    // tags and dirty marks
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (hit_reg) begin
                if (req_op_reg != OP_FETCH) begin
                    slot_dirty_reg[target_reg] <= 1'b1;
                end
            end else begin
                slot_file_reg[target_reg]  <= req_file_reg;
                slot_page_reg[target_reg]  <= req_page_reg;
                slot_dirty_reg[target_reg] <= (req_op_reg != OP_FETCH);
            end
        end
        if (cmd.scan_step && scan_match) begin
            slot_dirty_reg[scan_idx_reg] <= 1'b0;
        end
    end

    // old occupant of the chosen slot
    assign target_used = (slot_status_reg[target_reg] == SLOT_USED);
    assign old_wb      = !hit_reg && target_used && slot_dirty_reg[target_reg];

    assign target_ext = {{SLOT_OUT_W{1'b0}}, target_reg};
    assign scan_ext   = {{SLOT_OUT_W{1'b0}}, scan_idx_reg};

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_slot_reg    <= target_ext[SLOT_OUT_W-1:0];
            out_hit_reg     <= hit_reg;
            out_fill_reg    <= !hit_reg && (req_op_reg != OP_CREATE);
            out_wb_reg      <= old_wb;
            out_wb_file_reg <= old_wb ? slot_file_reg[target_reg] : '0;
            out_wb_page_reg <= old_wb ? slot_page_reg[target_reg] : '0;
            out_last_reg    <= 1'b1;
        end else if (cmd.scan_emit) begin
            out_slot_reg    <= scan_ext[SLOT_OUT_W-1:0];
            out_hit_reg     <= 1'b0;
            out_fill_reg    <= 1'b0;
            out_wb_reg      <= 1'b1;
            out_wb_file_reg <= slot_file_reg[scan_idx_reg];
            out_wb_page_reg <= slot_page_reg[scan_idx_reg];
            out_last_reg    <= 1'b0;
        end else if (cmd.close_last) begin
            out_slot_reg    <= '0;
            out_hit_reg     <= 1'b0;
            out_fill_reg    <= 1'b0;
            out_wb_reg      <= 1'b0;
            out_wb_file_reg <= '0;
            out_wb_page_reg <= '0;
            out_last_reg    <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit || cmd.scan_emit || cmd.close_last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_slot             = out_slot_reg;
    assign m_hit              = out_hit_reg;
    assign m_fill_needed      = out_fill_reg;
    assign m_writeback_needed = out_wb_reg;
    assign m_writeback_file   = out_wb_file_reg;
    assign m_writeback_page   = out_wb_page_reg;
    assign m_last             = out_last_reg;

    // status to the controller
    always_comb begin
        stat             = '0;
        stat.out_free    = !m_valid_reg || m_ready;
        stat.need_victim = !any_match && !any_never && !any_freed;
        stat.victim_done = victim_done;
        stat.scan_match  = scan_match;
        stat.scan_dirty  = slot_dirty_reg[scan_idx_reg];
        stat.scan_last   = (scan_idx_reg == SLOT_W'(SLOTS - 1));
    end

    `PBD_ASSERT(a_single_match, aclk, aresetn, $onehot0(match_vec), "page held in two slots")
    `PBD_ASSERT(a_hit_used, aclk, aresetn, (cmd.commit && hit_reg) |-> target_used, "hit on free slot")

endmodule

// ===== hw/rtl/page_buffer_directory_top.sv =====
// channel   direction  ports                                              handshake
// request   in         s_operation s_file_id s_page_number                s_valid / s_ready
// result    out        m_slot m_hit m_fill_needed m_writeback_needed      m_valid / m_ready
//                      m_writeback_file m_writeback_page m_last
//
// fetch or create: lookup, decide, then the result register loaded when the page is held
//   or a slot is free; when none is, a random victim is drawn before the result is loaded
//   (lfsr step, reciprocal multiply, remainder correction)
// close: one directory slot checked per cycle, stalled while a writeback waits
// reset: synchronous active-low aresetn marks every slot never used and reseeds the lfsr
// a full result register stalls the sequencer while it is held; one request in work

module page_buffer_directory_top import pbd_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  logic [FILE_W-1:0]     s_file_id,
    input  logic [PAGE_W-1:0]     s_page_number,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SLOT_OUT_W-1:0] m_slot,
    output logic                  m_hit,
    output logic                  m_fill_needed,
    output logic                  m_writeback_needed,
    output logic [FILE_W-1:0]     m_writeback_file,
    output logic [PAGE_W-1:0]     m_writeback_page,
    output logic                  m_last
);

    localparam int SLOT_W = $clog2(SLOTS);

    pbd_cmd_t          cmd;
    pbd_stat_t         stat;
    logic              victim_done;
    logic [SLOT_W-1:0] victim_slot;

    // sequencer
    pbd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .stat        (stat),
        .cmd         (cmd)
    );

    // random victim source
    pbd_victim #(.SLOTS(SLOTS)) u_victim (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (cmd.victim_start),
        .done        (victim_done),
        .victim_slot (victim_slot)
    );

    // directory and result register
    pbd_datapath #(.SLOTS(SLOTS)) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .s_operation        (s_operation),
        .s_file_id          (s_file_id),
        .s_page_number      (s_page_number),
        .victim_done        (victim_done),
        .victim_slot        (victim_slot),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_slot             (m_slot),
        .m_hit              (m_hit),
        .m_fill_needed      (m_fill_needed),
        .m_writeback_needed (m_writeback_needed),
        .m_writeback_file   (m_writeback_file),
        .m_writeback_page   (m_writeback_page),
        .m_last             (m_last)
    );

endmodule

// ===== tb/testbench.sv =====
module testbench import pbd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT     = 16;
    localparam int WATCHDOG_LIMIT = 1500;
    localparam int RANDOM_ITEMS   = 285;
    localparam int CALM_FIRST     = 130;
    localparam int CALM_END       = 190;

    // one page access or close as the driver presents it
    typedef struct {
        pbd_op_t               op;
        logic [FILE_W-1:0]     file_id;
        logic [PAGE_W-1:0]     page_number;
        bit                    wait_drained;
    } page_request_t;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic                  hit;
        logic                  fill_needed;
        logic                  writeback_needed;
        logic [FILE_W-1:0]     writeback_file;
        logic [PAGE_W-1:0]     writeback_page;
        logic                  last;
    } slot_report_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_operation = 2'd0;
    logic [FILE_W-1:0]     s_file_id = '0;
    logic [PAGE_W-1:0]     s_page_number = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [SLOT_OUT_W-1:0] m_slot;
    logic                  m_hit;
    logic                  m_fill_needed;
    logic                  m_writeback_needed;
    logic [FILE_W-1:0]     m_writeback_file;
    logic [PAGE_W-1:0]     m_writeback_page;
    logic                  m_last;

    page_request_t request_queue[$];
    slot_report_t  reports_due[$];

    // shadow copy of the directory
    slot_state_t       dir_state[SLOT_COUNT];
    logic [FILE_W-1:0] dir_file[SLOT_COUNT];
    logic [PAGE_W-1:0] dir_page[SLOT_COUNT];
    logic              dir_dirty[SLOT_COUNT];
    logic [15:0]       victim_seq = LFSR_SEED;

    logic req_fire = 1'b0;
    int   items_sent = 0;
    int   mismatch_count = 0;
    int   quiet_cycles = 0;
    logic calm;

    page_buffer_directory_top #(
        .SLOTS(SLOT_COUNT)
    ) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_file_id         (s_file_id),
        .s_page_number     (s_page_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_slot            (m_slot),
        .m_hit             (m_hit),
        .m_fill_needed     (m_fill_needed),
        .m_writeback_needed(m_writeback_needed),
        .m_writeback_file  (m_writeback_file),
        .m_writeback_page  (m_writeback_page),
        .m_last            (m_last)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    task automatic add_request(input pbd_op_t op, input logic [FILE_W-1:0] fid,
                               input logic [PAGE_W-1:0] page, input bit drain);
        page_request_t req;
        req.op = op;
        req.file_id = fid;
        req.page_number = page;
        req.wait_drained = drain;
        request_queue = {request_queue, req};
    endtask

    task automatic push_report(input int slot, input logic hit, input logic fill,
                               input logic wb, input logic [FILE_W-1:0] wb_file,
                               input logic [PAGE_W-1:0] wb_page, input logic last);
        slot_report_t rep;
        rep.slot = slot[SLOT_OUT_W-1:0];
        rep.hit = hit;
        rep.fill_needed = fill;
        rep.writeback_needed = wb;
        rep.writeback_file = wb_file;
        rep.writeback_page = wb_page;
        rep.last = last;
        reports_due = {reports_due, rep};
    endtask

    // apply one accepted request to the shadow directory and queue its reports
    task automatic update_directory(input pbd_op_t op, input logic [FILE_W-1:0] fid,
                                    input logic [PAGE_W-1:0] page);
        int   found;
        int   pick;
        int   freed;
        logic wb;
        logic lsb;
        found = -1;
        pick = -1;
        freed = -1;
        if (op == OP_CLOSE) begin
            // flush and release every slot of the file
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (dir_state[i] == SLOT_USED && dir_file[i] == fid) begin
                    if (dir_dirty[i])
                        push_report(i, 1'b0, 1'b0, 1'b1, dir_file[i], dir_page[i], 1'b0);
                    dir_state[i] = SLOT_FREED;
                    dir_dirty[i] = 1'b0;
                end
            end
            push_report(0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
        end else begin
            for (int i = SLOT_COUNT - 1; i >= 0; i--)
                if (dir_state[i] == SLOT_USED && dir_file[i] == fid && dir_page[i] == page)
                    found = i;
            if (found >= 0) begin
                if (op != OP_FETCH)
                    dir_dirty[found] = 1'b1;
                push_report(found, 1'b1, 1'b0, 1'b0, '0, '0, 1'b1);
            end else begin
                // lowest never-used slot, then highest released, then lfsr victim
                for (int i = SLOT_COUNT - 1; i >= 0; i--)
                    if (dir_state[i] == SLOT_NEVER)
                        pick = i;
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (dir_state[i] == SLOT_FREED)
                        freed = i;
                if (pick < 0 && freed >= 0)
                    pick = freed;
                if (pick < 0) begin
                    lsb = victim_seq[0];
                    victim_seq = victim_seq >> 1;
                    if (lsb)
                        victim_seq = victim_seq ^ LFSR_TAPS;
                    pick = int'(victim_seq) % SLOT_COUNT;
                end
                wb = (dir_state[pick] == SLOT_USED) && dir_dirty[pick];
                push_report(pick, 1'b0, op != OP_CREATE, wb,
                            wb ? dir_file[pick] : '0, wb ? dir_page[pick] : '0, 1'b1);
                dir_state[pick] = SLOT_USED;
                dir_file[pick] = fid;
                dir_page[pick] = page;
                dir_dirty[pick] = (op != OP_FETCH);
            end
        end
    endtask

    function automatic void check_field(input string field, input logic [31:0] expv,
                                        input logic [31:0] actv);
        if (expv !== actv) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, expv, actv);
            mismatch_count++;
        end
    endfunction

    task automatic check_report();
        slot_report_t due;
        if (reports_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, got slot %0h last %0b",
                     $time, m_slot, m_last);
            mismatch_count++;
        end else begin
            due = reports_due.pop_front();
            check_field("slot", 32'(due.slot), 32'(m_slot));
            check_field("hit", 32'(due.hit), 32'(m_hit));
            check_field("fill_needed", 32'(due.fill_needed), 32'(m_fill_needed));
            check_field("writeback_needed", 32'(due.writeback_needed),
                        32'(m_writeback_needed));
            check_field("writeback_file", 32'(due.writeback_file), 32'(m_writeback_file));
            check_field("writeback_page", 32'(due.writeback_page), 32'(m_writeback_page));
            check_field("last", 32'(due.last), 32'(m_last));
        end
    endtask

    assign calm = (items_sent >= CALM_FIRST) && (items_sent < CALM_END);

    // request driver, falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 23);
            if (!s_valid || req_fire) begin
                if (request_queue.size() > 0
                        && (!request_queue[0].wait_drained || reports_due.size() == 0)
                        && (calm || $urandom_range(99) >= 23)) begin
                    s_valid <= 1'b1;
                    s_operation <= request_queue[0].op;
                    s_file_id <= request_queue[0].file_id;
                    s_page_number <= request_queue[0].page_number;
                    void'(request_queue.pop_front());
                    items_sent <= items_sent + 1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor, rising edge: results first, then the newly accepted request
    always @(posedge aclk) begin
        if (!aresetn) begin
            req_fire <= 1'b0;
        end else begin
            req_fire <= s_valid && s_ready;
            if (m_valid && m_ready)
                check_report();
            if (s_valid && s_ready)
                update_directory(pbd_op_t'(s_operation), s_file_id, s_page_number);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int            pick_op;
        pbd_op_t       op;
        logic [FILE_W-1:0] fid;
        logic [PAGE_W-1:0] page;

        for (int i = 0; i < SLOT_COUNT; i++) begin
            dir_state[i] = SLOT_NEVER;
            dir_file[i] = '0;
            dir_page[i] = '0;
            dir_dirty[i] = 1'b0;
        end

        // directed: hits, held create, closes, filling, released reuse, victims
        add_request(OP_FETCH, 4'd0, 24'h000000, 1'b0);
        add_request(OP_FETCH, 4'd0, 24'h000000, 1'b0);
        add_request(OP_FETCH_DIRTY, 4'd15, 24'hFFFFFF, 1'b0);
        add_request(OP_CREATE, 4'd15, 24'hFFFFFF, 1'b0);
        add_request(OP_CREATE, 4'd3, 24'h123456, 1'b0);
        add_request(OP_FETCH_DIRTY, 4'd0, 24'h000000, 1'b0);
        add_request(OP_CLOSE, 4'd15, 24'hABCDEF, 1'b0);
        add_request(OP_CLOSE, 4'd9, 24'h000000, 1'b0);
        for (int i = 0; i < 13; i++)
            add_request((i % 2 == 0) ? OP_FETCH : OP_CREATE, 4'(4 + i % 3),
                        24'h000100 + 24'(i), 1'b0);
        add_request(OP_FETCH, 4'd1, 24'h555555, 1'b0);
        add_request(OP_FETCH_DIRTY, 4'd2, 24'hAAAAAA, 1'b0);
        add_request(OP_CLOSE, 4'd4, 24'h000000, 1'b0);
        add_request(OP_CLOSE, 4'd5, 24'h000000, 1'b1);

        // random: small working set for hits and evictions, some wide pages
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            pick_op = $urandom_range(99);
            if (pick_op < 35)
                op = OP_FETCH;
            else if (pick_op < 62)
                op = OP_FETCH_DIRTY;
            else if (pick_op < 88)
                op = OP_CREATE;
            else
                op = OP_CLOSE;
            fid = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
            page = ($urandom_range(9) == 0) ? 24'($urandom()) : 24'($urandom_range(23));
            add_request(op, fid, page, (k % 70) == 69);
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // wait for all requests taken and all results seen
        @(posedge aclk);
        while (request_queue.size() != 0 || s_valid || reports_due.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
